FILE: hw/rtl/page_table_map_unmap_walker_assert.svh
// Assertion macros for the page table walker.
`ifndef PAGE_TABLE_MAP_UNMAP_WALKER_ASSERT_SVH
`define PAGE_TABLE_MAP_UNMAP_WALKER_ASSERT_SVH

`ifndef SYNTHESIS
`define PTW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page table walker assertion failed");
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page table walker assertion failed");
`else
`define PTW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/ptw_pkg.sv
package ptw_pkg;

  localparam int NUM_FRAMES        = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int FRAME_W           = $clog2(NUM_FRAMES);
  localparam int ADDR_W            = FRAME_W + IDX_W;
  localparam int STORE_DEPTH       = NUM_FRAMES * ENTRIES_PER_TABLE;
  localparam int CNT_W             = $clog2(NUM_FRAMES + 1);
  localparam int PN_W              = 36;
  localparam int VA_W              = 48;
  localparam int DESC_W            = 64;
  localparam int REG_W             = 64;
  localparam int PADDR_W           = 5;

  localparam logic [DESC_W-1:0] DESC_VALID = 64'h1;
  localparam logic [DESC_W-1:0] DESC_TABLE = 64'h2;
  localparam logic [DESC_W-1:0] BIT_AF     = 64'h1 << 10;
  localparam logic [DESC_W-1:0] BIT_XN     = 64'h1 << 54;
  localparam logic [DESC_W-1:0] BIT_RO     = 64'h1 << 7;
  localparam logic [DESC_W-1:0] BIT_USER   = 64'h1 << 6;

  // Configuration register indexes (paddr[4:3]).
  localparam logic [1:0] REG_TABLE_BASE  = 2'd0;
  localparam logic [1:0] REG_DEVICE_ATTR = 2'd1;
  localparam logic [1:0] REG_NORMAL_ATTR = 2'd2;

  localparam logic [1:0] LEVEL_LEAF = 2'd3;
  localparam logic [1:0] LEVEL_LAST_TABLE = 2'd2;

  typedef enum logic {
    CMD_MAP   = 1'b0,
    CMD_UNMAP = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BLOCK    = 2'd1,
    ST_NO_FRAME = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_LEAF
  } walk_state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [VA_W-1:0]   vaddr;
    logic [PN_W-1:0]   page_frame;
    logic              execute_never;
    logic              read_only;
    logic              unprivileged;
    logic              device_memory;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [1:0]        fail_level;
    logic [DESC_W-1:0] leaf_descriptor;
    logic [6:0]        frames_used;
  } out_item_t;

  // Table index of a virtual address at a given level.
  function automatic logic [IDX_W-1:0] slot_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] level);
    logic [IDX_W-1:0] idx;
    case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

FILE: hw/rtl/ptw_ram.sv
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/page_table_map_unmap_walker.sv
// Four-level page table walker that maps and unmaps 4 KB pages in an
// internal table store of NUM_FRAMES frames of 512 descriptors each.
// An item on the in_ channel carries one map or unmap command; the block
// answers each with exactly one item on the out_ channel holding the
// status, the level where the walk stopped, the leaf descriptor and the
// number of table frames in use. Both channels use valid and stall.
// The walk issues one table read per level that it reaches, but a map
// does not read the leaf level; each read is an address step (S_READ),
// then evaluation of the registered read data (S_EVAL). A successful map
// ends with a leaf write in S_LEAF; an unmap, or a map that fails,
// returns its result from the evaluation of the last level it reaches.
// The block returns to idle, ready for the next item, as the result is loaded.
// One item is walked at a time; a finished result sits in the output
// register, and a stalled receiver holds the walk at its last step.
// After reset the store is cleared one entry per cycle through all
// NUM_FRAMES * 512 entries (32768 at the default size). No item is accepted
// during the clear; configuration writes over the APB port are taken at
// any time, and the registers return to their reset values.
module page_table_map_unmap_walker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ptw_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ptw_pkg::out_item_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ptw_pkg::PADDR_W-1:0]     paddr,
  input  logic [ptw_pkg::REG_W-1:0]       pwdata,
  output logic [ptw_pkg::REG_W-1:0]       prdata,
  output logic                            pready
);

  import ptw_pkg::*;

  walk_state_t          state_r, state_nxt;
  in_item_t             cmd_item_r;
  logic [1:0]           level_r, level_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  logic [CNT_W-1:0]     nff_r, nff_nxt;
  logic [ADDR_W-1:0]    clr_r;
  logic [PN_W-1:0]      base_r;
  logic [2:0]           dev_attr_r;
  logic [2:0]           norm_attr_r;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  logic                 cfg_write;
  logic                 in_fire;
  logic                 out_free;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [DESC_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [DESC_W-1:0]    ram_rdata;

  // Walk step decode.
  logic                 e_valid;
  logic                 frames_full;
  logic [PN_W-1:0]      alloc_pn;
  logic [DESC_W-1:0]    alloc_desc;
  logic [DESC_W-1:0]    e_eff;
  logic [PN_W-1:0]      frame_diff;
  logic                 outside;
  logic [DESC_W-1:0]    leaf_desc;
  logic [2:0]           attr_sel;
  logic                 emit_req;
  status_t              emit_status;
  logic                 advance;
  logic                 hold;
  logic                 do_alloc;
  logic                 emit_fire;

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      dev_attr_r  <= 3'd0;
      norm_attr_r <= 3'd1;
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        REG_TABLE_BASE:  base_r      <= pwdata[PN_W-1:0];
        REG_DEVICE_ATTR: dev_attr_r  <= pwdata[2:0];
        REG_NORMAL_ATTR: norm_attr_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_TABLE_BASE:  prdata = REG_W'(base_r);
      REG_DEVICE_ATTR: prdata = REG_W'(dev_attr_r);
      REG_NORMAL_ATTR: prdata = REG_W'(norm_attr_r);
      default:         prdata = '0;
    endcase
  end

  ptw_ram #(
    .WIDTH(DESC_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Evaluate the descriptor read for the current level. A missing table is
  // replaced by the descriptor of a freshly allocated frame.
  always_comb begin
    e_valid     = ram_rdata[0];
    frames_full = (nff_r == CNT_W'(NUM_FRAMES));
    alloc_pn    = base_r + PN_W'(nff_r);
    alloc_desc  = (DESC_W'(alloc_pn) << 12) | DESC_TABLE | DESC_VALID;
    e_eff       = e_valid ? ram_rdata : alloc_desc;
    frame_diff  = e_eff[47:12] - base_r;
    outside     = (frame_diff >= PN_W'(NUM_FRAMES));
    attr_sel    = cmd_item_r.device_memory ? dev_attr_r : norm_attr_r;
    leaf_desc   = (DESC_W'(cmd_item_r.page_frame) << 12) | BIT_AF | DESC_TABLE
                | DESC_VALID | (DESC_W'(attr_sel) << 2)
                | (cmd_item_r.execute_never ? BIT_XN : '0)
                | (cmd_item_r.read_only ? BIT_RO : '0)
                | (cmd_item_r.unprivileged ? BIT_USER : '0);

    emit_req    = 1'b0;
    emit_status = ST_OK;
    advance     = 1'b0;
    if (cmd_item_r.cmd == CMD_MAP) begin
      if (!e_valid && frames_full) begin
        emit_req    = 1'b1;
        emit_status = ST_NO_FRAME;
      end else if (!e_eff[1]) begin
        emit_req    = 1'b1;
        emit_status = ST_BLOCK;
      end else if (outside) begin
        emit_req    = 1'b1;
        emit_status = ST_OUTSIDE;
      end else begin
        advance = 1'b1;
      end
    end else begin
      if (!e_valid) begin
        emit_req    = 1'b1;
        emit_status = ST_OK;
      end else if (!e_eff[1]) begin
        emit_req    = 1'b1;
        emit_status = ST_BLOCK;
      end else if (level_r == LEVEL_LEAF) begin
        emit_req    = 1'b1;
        emit_status = ST_OK;
      end else if (outside) begin
        emit_req    = 1'b1;
        emit_status = ST_OUTSIDE;
      end else begin
        advance = 1'b1;
      end
    end

    // A finishing step waits in place until the output register is free.
    hold     = emit_req && !out_free;
    do_alloc = (cmd_item_r.cmd == CMD_MAP) && !e_valid && !frames_full && !hold;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // A map writes its leaf directly; an unmap reads the leaf first.
        if (advance) begin
          state_nxt = ((cmd_item_r.cmd == CMD_MAP) && (level_r == LEVEL_LAST_TABLE))
                    ? S_LEAF : S_READ;
        end else if (!hold) begin
          state_nxt = S_IDLE;
        end
      end
      S_LEAF: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Outputs of the walk: store accesses, walk position and result.
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = {frame_r, slot_index(cmd_item_r.vaddr, level_r)};
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = {frame_r, slot_index(cmd_item_r.vaddr, level_r)};
    level_nxt     = level_r;
    frame_nxt     = frame_r;
    nff_nxt       = nff_r;
    emit_fire     = 1'b0;
    out_nxt       = out_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      S_IDLE: begin
        level_nxt = 2'd0;
        frame_nxt = '0;
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_EVAL: begin
        if (do_alloc) begin
          ram_we    = 1'b1;
          ram_wdata = alloc_desc;
          nff_nxt   = nff_r + CNT_W'(1);
        end
        if (advance) begin
          level_nxt = level_r + 2'd1;
          frame_nxt = frame_diff[FRAME_W-1:0];
        end else if (!hold) begin
          if ((cmd_item_r.cmd == CMD_UNMAP) && (emit_status == ST_OK) && e_valid) begin
            // Clearing a mapped leaf.
            ram_we    = 1'b1;
            ram_wdata = '0;
          end
          emit_fire                = 1'b1;
          out_nxt.status           = emit_status;
          out_nxt.fail_level       = level_r;
          out_nxt.leaf_descriptor  = '0;
          out_nxt.frames_used      = 7'(nff_nxt);
        end
      end
      S_LEAF: begin
        if (out_free) begin
          ram_we                   = 1'b1;
          ram_waddr                = {frame_r, slot_index(cmd_item_r.vaddr, LEVEL_LEAF)};
          ram_wdata                = leaf_desc;
          emit_fire                = 1'b1;
          out_nxt.status           = ST_OK;
          out_nxt.fail_level       = LEVEL_LEAF;
          out_nxt.leaf_descriptor  = leaf_desc;
          out_nxt.frames_used      = 7'(nff_r);
        end
      end
      default: ;
    endcase

    out_valid_nxt = emit_fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      nff_r       <= CNT_W'(1);
      level_r     <= 2'd0;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nff_r       <= nff_nxt;
      level_r     <= level_nxt;
      frame_r     <= frame_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_item_r <= in_data;
    end
    if (emit_fire) begin
      out_r <= out_nxt;
    end
  end

  `include "page_table_map_unmap_walker_assert.svh"

  `PTW_ASSERT_IMPLIES(a_frame_count_range, clk, rst_n, 1'b1, (nff_r != '0) && (nff_r <= CNT_W'(NUM_FRAMES)))
  `PTW_ASSERT_IMPLIES(a_store_write_state, clk, rst_n, ram_we, (state_r == S_CLEAR) || (state_r == S_EVAL) || (state_r == S_LEAF))
  `PTW_ASSERT_IMPLIES(a_map_level_bound, clk, rst_n, (state_r == S_READ) && (cmd_item_r.cmd == CMD_MAP), level_r != LEVEL_LEAF)
  `PTW_ASSERT_NEXT(a_result_loaded, clk, rst_n, emit_fire, out_valid_r)

endmodule
